@@ src/bba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Request and result types and operation codes shared by the buddy allocator
// block and its checker.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] request_bytes;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] block_address;
  } out_item_t;

endpackage

@@ src/buddy_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator with split bitmap, per-level free lists and lazy tree growth.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready/in_data: an allocate of a byte count
//   or a free of an address. Each request produces exactly one result on
//   out_valid/out_ready/out_data. heap_base is written through the APB-style
//   port (psel/penable/pwrite/paddr/pwdata); the user must write it only while
//   the block is idle, and the block does not enforce this. One request is in
//   work at a time; in_ready is high only in the idle state. A small
//   sequencer walks tree levels and list links, one step per cycle. An
//   oversize allocate goes straight to the result state and a free of null
//   passes through the free end state first. A free reads the block's level
//   and merges with free buddies level by level. An allocate climbs the size
//   search, steps down past empty levels, grows the tree and splits blocks.
//   A list unlink has a read state and a write state, as the link memories
//   have registered read data. in_ready returns after the result is loaded.
//   The finished result sits in an output register, so a new request is taken
//   while the receiver stalls; the sequencer then waits in its last state
//   until the output register is free.
//   Reset (synchronous, rst_n low) clears the split bitmap, sets all list
//   heads empty except the smallest level, which holds block 0, and sets the
//   tree limit to the smallest level. No clearing pass is needed.
// ----------------------------------------------------------------------------
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int LEVELS         = 8,
  parameter int MIN_BLOCK_LOG2 = 5,
  parameter int HEADER_BYTES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NBLK    = 1 << (LEVELS - 1);
  localparam int BLK_W   = LEVELS - 1;
  localparam int ID_W    = LEVELS;
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int TOP_LOG2 = MIN_BLOCK_LOG2 + LEVELS - 1;
  localparam logic [31:0] HEAP_BYTES = 32'(1) << TOP_LOG2;
  localparam logic [ID_W-1:0] NBLK_ID  = ID_W'(NBLK);
  localparam logic [ID_W-1:0] HEAD_TOP = ID_W'(NBLK + LEVELS - 1);
  localparam logic [ID_W-1:0] LEVELS_ID = ID_W'(LEVELS);
  localparam logic [LVL_W-1:0] LV_TOP = LVL_W'(LEVELS - 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_LVL     = 5'd1;
  localparam logic [4:0] S_GROW    = 5'd2;
  localparam logic [4:0] S_G_A1    = 5'd3;
  localparam logic [4:0] S_G_B1    = 5'd4;
  localparam logic [4:0] S_A_TRY   = 5'd5;
  localparam logic [4:0] S_A_POP1  = 5'd6;
  localparam logic [4:0] S_A_POP2  = 5'd7;
  localparam logic [4:0] S_A_FOUND = 5'd8;
  localparam logic [4:0] S_A_SPLIT = 5'd9;
  localparam logic [4:0] S_F_RD    = 5'd10;
  localparam logic [4:0] S_F_LV    = 5'd11;
  localparam logic [4:0] S_F_LOOP  = 5'd12;
  localparam logic [4:0] S_F_END   = 5'd13;
  localparam logic [4:0] S_RM_RD   = 5'd14;
  localparam logic [4:0] S_RM_WR   = 5'd15;
  localparam logic [4:0] S_PU_1    = 5'd16;
  localparam logic [4:0] S_PU_2    = 5'd17;
  localparam logic [4:0] S_DONE    = 5'd18;

  function automatic logic [ID_W-1:0] node_of(input logic [BLK_W-1:0] id,
                                              input logic [LVL_W-1:0] lv);
    logic [ID_W-1:0] sh;
    logic [ID_W-1:0] base;
    sh   = ID_W'(id) >> (LV_TOP - lv);
    base = (ID_W'(1) << lv) - ID_W'(1);
    return sh + base;
  endfunction

  function automatic logic [BLK_W-1:0] blk_of(input logic [ID_W-1:0] node,
                                              input logic [LVL_W-1:0] lv);
    logic [ID_W-1:0] t;
    t = node + ID_W'(1) - (ID_W'(1) << lv);
    t = t << (LV_TOP - lv);
    return t[BLK_W-1:0];
  endfunction

  // Pair index of a node; node 0 wraps to the last pair bit.
  function automatic logic [BLK_W-1:0] pidx(input logic [ID_W-1:0] node);
    logic [ID_W-1:0] t;
    t = node - ID_W'(1);
    return t[ID_W-1:1];
  endfunction

  function automatic logic is_head(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] t;
    t = id - NBLK_ID;
    return (id >= NBLK_ID) && (t < LEVELS_ID);
  endfunction

  function automatic logic [LVL_W-1:0] head_lv(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] t;
    t = id - NBLK_ID;
    return t[LVL_W-1:0];
  endfunction

  logic [4:0]       state_r, state_nxt;
  logic [4:0]       ret_r, ret_nxt;
  logic [4:0]       gret_r, gret_nxt;
  logic [LVL_W-1:0] lv_r, lv_nxt;
  logic [LVL_W-1:0] want_r, want_nxt;
  logic [LVL_W-1:0] limit_r, limit_nxt;
  logic [LVL_W-1:0] gt_r, gt_nxt;
  logic [BLK_W-1:0] id_r, id_nxt;
  logic [ID_W-1:0]  node_r, node_nxt;
  logic [31:0]      size_r, size_nxt;
  logic [16:0]      bytes_r, bytes_nxt;
  logic [BLK_W-1:0] rm_e_r, rm_e_nxt;
  logic [LVL_W-1:0] pu_lv_r, pu_lv_nxt;
  logic [BLK_W-1:0] pu_e_r, pu_e_nxt;
  logic [ID_W-1:0]  pu_p_r, pu_p_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic [31:0]      res_addr_r, res_addr_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic [31:0]      heap_base_r;
  logic [NBLK-1:0]  split_r;
  logic             p0v_r, n0v_r;
  logic [ID_W-1:0]  head_prev_r [LEVELS];
  logic [ID_W-1:0]  head_next_r [LEVELS];

  logic [ID_W-1:0]  mem_prev [NBLK];
  logic [ID_W-1:0]  mem_next [NBLK];
  logic [LVL_W-1:0] mem_al [NBLK];
  logic [ID_W-1:0]  q_prev_r, q_next_r;
  logic [LVL_W-1:0] q_al_r;

  // Write requests decoded each cycle.
  logic             wp_en, wn_en, hp_en, hinit_en, flip_en, al_we;
  logic [ID_W-1:0]  wp_id, wp_val, wn_id, wn_val, hp_val;
  logic [LVL_W-1:0] hp_lv, hinit_lv;
  logic [BLK_W-1:0] flip_idx;

  logic [ID_W-1:0]  rm_p, rm_n, back, root, nn;
  logic [LVL_W-1:0] fl_lv;
  logic [31:0]      diff;
  logic             cur_bit;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = heap_base_r;

  assign rm_p = (rm_e_r == '0 && !p0v_r) ? HEAD_TOP : q_prev_r;
  assign rm_n = (rm_e_r == '0 && !n0v_r) ? HEAD_TOP : q_next_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    gret_nxt      = gret_r;
    lv_nxt        = lv_r;
    want_nxt      = want_r;
    limit_nxt     = limit_r;
    gt_nxt        = gt_r;
    id_nxt        = id_r;
    node_nxt      = node_r;
    size_nxt      = size_r;
    bytes_nxt     = bytes_r;
    rm_e_nxt      = rm_e_r;
    pu_lv_nxt     = pu_lv_r;
    pu_e_nxt      = pu_e_r;
    pu_p_nxt      = pu_p_r;
    res_ok_nxt    = res_ok_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wp_en = 1'b0; wp_id = '0; wp_val = '0;
    wn_en = 1'b0; wn_id = '0; wn_val = '0;
    hp_en = 1'b0; hp_lv = '0; hp_val = '0;
    hinit_en = 1'b0; hinit_lv = '0;
    flip_en = 1'b0; flip_idx = '0;
    al_we = 1'b0;
    back  = head_prev_r[lv_r];
    root  = (ID_W'(1) << limit_r) - ID_W'(1);
    nn    = {node_r[ID_W-2:0], 1'b1};
    fl_lv = (ID_W'(q_al_r) >= LEVELS_ID) ? '0 : q_al_r;
    diff  = in_data.address - heap_base_r - 32'(HEADER_BYTES);
    cur_bit = split_r[pidx(node_r)];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_ok_nxt   = 1'b0;
          res_addr_nxt = '0;
          if (in_data.mode == MODE_ALLOC) begin
            bytes_nxt = 17'(in_data.request_bytes) + 17'(HEADER_BYTES);
            if (32'(17'(in_data.request_bytes) + 17'(HEADER_BYTES)) > HEAP_BYTES) begin
              state_nxt = S_DONE;
            end else begin
              lv_nxt    = LV_TOP;
              size_nxt  = 32'(1) << MIN_BLOCK_LOG2;
              state_nxt = S_LVL;
            end
          end else if (in_data.address == '0) begin
            state_nxt = S_F_END;
          end else begin
            id_nxt    = diff[MIN_BLOCK_LOG2 +: BLK_W];
            state_nxt = S_F_RD;
          end
        end
      end
      S_LVL: begin
        if (size_r < 32'(bytes_r) && lv_r != '0) begin
          size_nxt = size_r << 1;
          lv_nxt   = lv_r - LVL_W'(1);
        end else begin
          want_nxt  = lv_r;
          state_nxt = S_A_TRY;
        end
      end
      S_GROW: begin
        if (gt_r < limit_r) begin
          if (!split_r[pidx(root)]) begin
            rm_e_nxt  = '0;
            ret_nxt   = S_G_A1;
            state_nxt = S_RM_RD;
          end else begin
            pu_lv_nxt = limit_r;
            pu_e_nxt  = blk_of(root + ID_W'(1), limit_r);
            ret_nxt   = S_G_B1;
            state_nxt = S_PU_1;
          end
        end else begin
          state_nxt = gret_r;
        end
      end
      S_G_A1: begin
        limit_nxt = limit_r - LVL_W'(1);
        hinit_en  = 1'b1;
        hinit_lv  = limit_r - LVL_W'(1);
        pu_lv_nxt = limit_r - LVL_W'(1);
        pu_e_nxt  = '0;
        ret_nxt   = S_GROW;
        state_nxt = S_PU_1;
      end
      S_G_B1: begin
        limit_nxt = limit_r - LVL_W'(1);
        hinit_en  = 1'b1;
        hinit_lv  = limit_r - LVL_W'(1);
        if (limit_r != LVL_W'(1)) begin
          flip_en  = 1'b1;
          flip_idx = pidx((ID_W'(1) << (limit_r - LVL_W'(1))) - ID_W'(1));
        end
        state_nxt = S_GROW;
      end
      S_A_TRY: begin
        gt_nxt    = lv_r;
        gret_nxt  = S_A_POP1;
        state_nxt = S_GROW;
      end
      S_A_POP1, S_A_POP2: begin
        if (back < NBLK_ID) begin
          id_nxt    = back[BLK_W-1:0];
          rm_e_nxt  = back[BLK_W-1:0];
          ret_nxt   = S_A_FOUND;
          state_nxt = S_RM_RD;
        end else if (state_r == S_A_POP1 && lv_r == limit_r && lv_r != '0) begin
          gt_nxt    = lv_r - LVL_W'(1);
          gret_nxt  = S_A_POP2;
          state_nxt = S_GROW;
        end else if (lv_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          lv_nxt    = lv_r - LVL_W'(1);
          state_nxt = S_A_TRY;
        end
      end
      S_A_FOUND: begin
        node_nxt = node_of(id_r, lv_r);
        if (node_of(id_r, lv_r) != '0) begin
          flip_en  = 1'b1;
          flip_idx = pidx(node_of(id_r, lv_r));
        end
        state_nxt = S_A_SPLIT;
      end
      S_A_SPLIT: begin
        if (lv_r < want_r) begin
          flip_en   = 1'b1;
          flip_idx  = pidx(nn);
          node_nxt  = nn;
          lv_nxt    = lv_r + LVL_W'(1);
          pu_lv_nxt = lv_r + LVL_W'(1);
          pu_e_nxt  = blk_of(nn + ID_W'(1), lv_r + LVL_W'(1));
          ret_nxt   = S_A_SPLIT;
          state_nxt = S_PU_1;
        end else begin
          al_we        = 1'b1;
          res_ok_nxt   = 1'b1;
          res_addr_nxt = heap_base_r + (32'(id_r) << MIN_BLOCK_LOG2) + 32'(HEADER_BYTES);
          state_nxt    = S_DONE;
        end
      end
      S_F_RD: begin
        state_nxt = S_F_LV;
      end
      S_F_LV: begin
        lv_nxt    = fl_lv;
        node_nxt  = node_of(id_r, fl_lv);
        state_nxt = S_F_LOOP;
      end
      S_F_LOOP: begin
        if (node_r == '0) begin
          pu_lv_nxt = lv_r;
          pu_e_nxt  = blk_of(node_r, lv_r);
          ret_nxt   = S_F_END;
          state_nxt = S_PU_1;
        end else begin
          flip_en  = 1'b1;
          flip_idx = pidx(node_r);
          if (!cur_bit || lv_r == limit_r) begin
            pu_lv_nxt = lv_r;
            pu_e_nxt  = blk_of(node_r, lv_r);
            ret_nxt   = S_F_END;
            state_nxt = S_PU_1;
          end else begin
            // Unlink the free buddy and step up to the parent.
            rm_e_nxt  = blk_of(((node_r - ID_W'(1)) ^ ID_W'(1)) + ID_W'(1), lv_r);
            node_nxt  = (node_r - ID_W'(1)) >> 1;
            lv_nxt    = lv_r - LVL_W'(1);
            ret_nxt   = S_F_LOOP;
            state_nxt = S_RM_RD;
          end
        end
      end
      S_F_END: begin
        res_ok_nxt   = 1'b1;
        res_addr_nxt = '0;
        state_nxt    = S_DONE;
      end
      S_RM_RD: begin
        state_nxt = S_RM_WR;
      end
      S_RM_WR: begin
        wn_en  = 1'b1;
        wn_id  = rm_p;
        wn_val = rm_n;
        wp_en  = 1'b1;
        wp_id  = rm_n;
        wp_val = rm_p;
        state_nxt = ret_r;
      end
      S_PU_1: begin
        wp_en  = 1'b1;
        wp_id  = ID_W'(pu_e_r);
        wp_val = head_prev_r[pu_lv_r];
        wn_en  = 1'b1;
        wn_id  = ID_W'(pu_e_r);
        wn_val = NBLK_ID + ID_W'(pu_lv_r);
        hp_en  = 1'b1;
        hp_lv  = pu_lv_r;
        hp_val = ID_W'(pu_e_r);
        pu_p_nxt  = head_prev_r[pu_lv_r];
        state_nxt = S_PU_2;
      end
      S_PU_2: begin
        wn_en  = 1'b1;
        wn_id  = pu_p_r;
        wn_val = ID_W'(pu_e_r);
        state_nxt = ret_r;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.ok = res_ok_r;
          out_data_nxt.block_address = res_addr_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      gret_r      <= S_IDLE;
      limit_r     <= LV_TOP;
      out_valid_r <= 1'b0;
      heap_base_r <= '0;
      split_r     <= '0;
      p0v_r       <= 1'b0;
      n0v_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      gret_r      <= gret_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && !paddr[2]) begin
        heap_base_r <= pwdata;
      end
      if (flip_en) begin
        split_r[flip_idx] <= ~split_r[flip_idx];
      end
      if (wp_en && wp_id == '0) begin
        p0v_r <= 1'b1;
      end
      if (wn_en && wn_id == '0) begin
        n0v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    lv_r       <= lv_nxt;
    want_r     <= want_nxt;
    gt_r       <= gt_nxt;
    id_r       <= id_nxt;
    node_r     <= node_nxt;
    size_r     <= size_nxt;
    bytes_r    <= bytes_nxt;
    rm_e_r     <= rm_e_nxt;
    pu_lv_r    <= pu_lv_nxt;
    pu_e_r     <= pu_e_nxt;
    pu_p_r     <= pu_p_nxt;
    res_ok_r   <= res_ok_nxt;
    res_addr_r <= res_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  // List heads: the smallest level starts holding block 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_prev_r[l] <= (l == LEVELS - 1) ? '0 : ID_W'(NBLK + l);
        head_next_r[l] <= (l == LEVELS - 1) ? '0 : ID_W'(NBLK + l);
      end
    end else begin
      if (hinit_en) begin
        head_prev_r[hinit_lv] <= NBLK_ID + ID_W'(hinit_lv);
        head_next_r[hinit_lv] <= NBLK_ID + ID_W'(hinit_lv);
      end
      if (wp_en && is_head(wp_id)) begin
        head_prev_r[head_lv(wp_id)] <= wp_val;
      end
      if (wn_en && is_head(wn_id)) begin
        head_next_r[head_lv(wn_id)] <= wn_val;
      end
      if (hp_en) begin
        head_prev_r[hp_lv] <= hp_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wp_en && wp_id < NBLK_ID) begin
      mem_prev[wp_id[BLK_W-1:0]] <= wp_val;
    end
    q_prev_r <= mem_prev[rm_e_r];
  end

  always_ff @(posedge clk) begin
    if (wn_en && wn_id < NBLK_ID) begin
      mem_next[wn_id[BLK_W-1:0]] <= wn_val;
    end
    q_next_r <= mem_next[rm_e_r];
  end

  always_ff @(posedge clk) begin
    if (al_we) begin
      mem_al[id_r] <= want_r;
    end
    q_al_r <= mem_al[id_r];
  end

endmodule

@@ src/bba_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// Port-level assertions for the buddy allocator, bound into buddy_block_allocator.
// ----------------------------------------------------------------------------
module bba_checker
  import bba_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      pready
);

  // A result waiting for the receiver must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A failed allocate must report a zero address (a free succeeds with address zero).
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.ok || out_data.block_address == 32'd0)
    else $error("failed request carries an address");

  // The sequencer leaves idle in the cycle after each accepted request.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("configuration port stalled");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
